@@ design/seven_segment_scan_serializer_unit_assert.svh @@
// Assertion macros for the checker file of the display serializer.
`ifndef SEVEN_SEGMENT_SCAN_SERIALIZER_UNIT_ASSERT_SVH
`define SEVEN_SEGMENT_SCAN_SERIALIZER_UNIT_ASSERT_SVH

// The consequent must hold in the clock after the antecedent.
`define SSSU_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle assertion failed");

// The consequent must hold in the same clock as the antecedent.
`define SSSU_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle assertion failed");

`endif

@@ design/sssu_pkg.sv @@
// Types, constants and the segment table of the display serializer.
package sssu_pkg;

   localparam int WORD_WIDTH  = 16;
   localparam int DIGIT_COUNT = 4;

   localparam logic [7:0]  SELECT_UNITS = 8'h08;
   localparam logic [15:0] DIV10_RECIP  = 16'hCCCD;
   localparam int          DIV10_SHIFT  = 19;
   localparam logic [3:0]  BIT_LAST     = 4'd15;

   typedef struct packed {
      logic        mode;
      logic [15:0] number;
   } req_payload_type;

   typedef struct packed {
      logic serial_bit;
      logic last;
   } rsp_payload_type;

   typedef struct packed {
      logic                  valid;
      logic [WORD_WIDTH-1:0] word;
   } queue_entry_type;

   typedef enum logic {
      FRONT_IDLE,
      FRONT_CONVERT
   } front_state_type;

   // Active-low common-anode segment code of one decimal digit.
   function automatic logic [7:0] seg_code(input logic [3:0] digit);
      logic [7:0] code;
      unique case (digit)
         4'd0:    code = 8'hC0;
         4'd1:    code = 8'hF9;
         4'd2:    code = 8'hA4;
         4'd3:    code = 8'hB0;
         4'd4:    code = 8'h99;
         4'd5:    code = 8'h92;
         4'd6:    code = 8'h82;
         4'd7:    code = 8'hF8;
         4'd8:    code = 8'h80;
         4'd9:    code = 8'h90;
         default: code = 8'hFF;
      endcase
      return code;
   endfunction

endpackage

@@ design/seven_segment_scan_serializer_unit.sv @@
// Top level of the four-digit seven-segment scan serializer.
//
// Usage: the req channel takes one item per transfer. mode = 1 loads a new
// 16-bit number and turns the display on; mode = 0 is a refresh tick. Each
// tick after the first load produces sixteen transfers on the rsp channel:
// the one-hot digit select byte, then the active-low segment byte, both MSB
// first, with last set on the sixteenth bit to mark the latch pulse.
// Ticks before the first load produce nothing.
// A tick's word is written into the queue and then loaded into the serializer's
// shift register before its first bit is offered. The serializer sends one bit
// per cycle while the receiver is ready and goes straight on to the next queued
// word after a last bit; the queue absorbs QUEUE_DEPTH ticks while earlier
// words are still shifting out.
// A load occupies the front end for one transfer plus four decimal digit
// steps through the shared divide-by-ten unit, and req_ready stays low
// meanwhile. Words already queued keep shifting during a load.
// Reset clears the display flag, the scan position, the queue and the
// serializer. When the receiver stalls, the current bit holds; once the
// queue fills, req_ready drops until a word drains.
module seven_segment_scan_serializer_unit #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  sssu_pkg::req_payload_type req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sssu_pkg::rsp_payload_type rsp_data
);

   // Word pushed by the front end, and the queue head seen by the back end.
   sssu_pkg::queue_entry_type push;
   sssu_pkg::queue_entry_type head;
   logic                      queue_full;
   logic                      pop;

   sssu_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .push       (push),
      .queue_full (queue_full)
   );

   sssu_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .head  (head),
      .pop   (pop),
      .full  (queue_full)
   );

   sssu_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/sssu_front.sv @@
// Front end: accepts items, keeps the display state and builds one word per tick once a number is loaded.
module sssu_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sssu_pkg::req_payload_type req_data,
   output sssu_pkg::queue_entry_type push,
   input  logic                     queue_full
);

   sssu_pkg::front_state_type state_ff, state_in;

   logic        shown_ff;
   logic [1:0]  scan_ff;
   logic [1:0]  count_m1_ff;
   logic [15:0] work_ff;
   logic [1:0]  step_ff;
   logic [3:0]  digit_ff [sssu_pkg::DIGIT_COUNT];

   logic        req_accept;
   logic        load_fire;
   logic        tick_fire;
   logic        converting;
   logic [31:0] product;
   logic [12:0] quo;
   logic [15:0] rem_wide;
   logic [1:0]  count_m1_in;
   logic [1:0]  scan_in;

   // Next scan position: (position + 1) modulo the number of significant digits.
   function automatic logic [1:0] next_scan(input logic [1:0] pos, input logic [1:0] cnt_m1);
      logic [1:0] nxt;
      unique case (cnt_m1)
         2'd0:    nxt = 2'd0;
         2'd1:    nxt = {1'b0, ~pos[0]};
         2'd2:    nxt = (pos == 2'd0) ? 2'd1 : (pos == 2'd1) ? 2'd2 :
                        (pos == 2'd2) ? 2'd0 : 2'd1;
         default: nxt = pos + 2'd1;
      endcase
      return nxt;
   endfunction

   assign req_accept = req_valid && req_ready;
   assign load_fire  = req_accept && req_data.mode;
   assign tick_fire  = req_accept && !req_data.mode && shown_ff;

   // One decimal digit per conversion step, by reciprocal multiplication.
   assign product  = 32'(work_ff) * 32'(sssu_pkg::DIV10_RECIP);
   assign quo      = product[31:sssu_pkg::DIV10_SHIFT];
   assign rem_wide = work_ff - 16'({quo, 3'b000}) - 16'({quo, 1'b0});

   always_comb begin
      priority if (req_data.number > 16'd999) begin
         count_m1_in = 2'd3;
      end else if (req_data.number > 16'd99) begin
         count_m1_in = 2'd2;
      end else if (req_data.number > 16'd9) begin
         count_m1_in = 2'd1;
      end else begin
         count_m1_in = 2'd0;
      end
   end

   assign scan_in = next_scan(scan_ff, count_m1_ff);

   always_comb begin
      push.valid = tick_fire;
      push.word  = {8'(sssu_pkg::SELECT_UNITS >> scan_ff), sssu_pkg::seg_code(digit_ff[scan_ff])};
   end

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         sssu_pkg::FRONT_IDLE: begin
            if (load_fire) begin
               state_in = sssu_pkg::FRONT_CONVERT;
            end
         end
         sssu_pkg::FRONT_CONVERT: begin
            if (step_ff == 2'(sssu_pkg::DIGIT_COUNT - 1)) begin
               state_in = sssu_pkg::FRONT_IDLE;
            end
         end
         default: state_in = sssu_pkg::FRONT_IDLE;
      endcase
   end

   // Output logic.
   always_comb begin
      unique case (state_ff)
         sssu_pkg::FRONT_IDLE: begin
            req_ready  = !queue_full;
            converting = 1'b0;
         end
         sssu_pkg::FRONT_CONVERT: begin
            req_ready  = 1'b0;
            converting = 1'b1;
         end
         default: begin
            req_ready  = 1'b0;
            converting = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= sssu_pkg::FRONT_IDLE;
         shown_ff <= 1'b0;
         scan_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (load_fire) begin
            shown_ff <= 1'b1;
         end
         if (tick_fire) begin
            scan_ff <= scan_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         work_ff     <= req_data.number;
         step_ff     <= 2'd0;
         count_m1_ff <= count_m1_in;
      end else if (converting) begin
         digit_ff[step_ff] <= rem_wide[3:0];
         work_ff           <= 16'(quo);
         step_ff           <= step_ff + 2'd1;
      end
   end

endmodule

@@ design/sssu_queue.sv @@
// Small word queue between the front end and the serializer.
module sssu_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  sssu_pkg::queue_entry_type push,
   output sssu_pkg::queue_entry_type head,
   input  logic                      pop,
   output logic                      full
);

   localparam int PtrWidth   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [sssu_pkg::WORD_WIDTH-1:0] entry_ff [DEPTH];
   logic [PtrWidth-1:0]             wr_ptr_ff;
   logic [PtrWidth-1:0]             rd_ptr_ff;
   logic [CountWidth-1:0]           count_ff;
   logic                            do_push;
   logic                            do_pop;

   function automatic logic [PtrWidth-1:0] bump(input logic [PtrWidth-1:0] ptr);
      return (ptr == PtrWidth'(DEPTH - 1)) ? '0 : ptr + PtrWidth'(1);
   endfunction

   assign full       = (count_ff == CountWidth'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.word  = entry_ff[rd_ptr_ff];
   assign do_push    = push.valid && !full;
   assign do_pop     = pop && head.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= bump(wr_ptr_ff);
         end
         if (do_pop) begin
            rd_ptr_ff <= bump(rd_ptr_ff);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CountWidth'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CountWidth'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push.word;
      end
   end

endmodule

@@ design/sssu_back.sv @@
// Back end: shifts each queued word out one bit per transfer, MSB first.
module sssu_back (
   input  logic                      clock,
   input  logic                      reset,
   input  sssu_pkg::queue_entry_type head,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output sssu_pkg::rsp_payload_type rsp_data
);

   logic                            busy_ff;
   logic [sssu_pkg::WORD_WIDTH-1:0] shift_ff;
   logic [3:0]                      bit_ff;
   logic                            fire;
   logic                            end_word;

   assign rsp_valid           = busy_ff;
   assign rsp_data.serial_bit = shift_ff[sssu_pkg::WORD_WIDTH-1];
   assign rsp_data.last       = (bit_ff == sssu_pkg::BIT_LAST);

   assign fire     = busy_ff && rsp_ready;
   assign end_word = fire && rsp_data.last;
   assign pop      = head.valid && (!busy_ff || end_word);

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (pop) begin
         busy_ff <= 1'b1;
      end else if (end_word) begin
         busy_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         shift_ff <= head.word;
         bit_ff   <= 4'd0;
      end else if (fire) begin
         shift_ff <= {shift_ff[sssu_pkg::WORD_WIDTH-2:0], 1'b0};
         bit_ff   <= bit_ff + 4'd1;
      end
   end

endmodule

@@ design/sssu_checker.sv @@
// Port-level checker for the display serializer and its bind statement.
`include "seven_segment_scan_serializer_unit_assert.svh"

module sssu_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input sssu_pkg::req_payload_type req_data,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input sssu_pkg::rsp_payload_type rsp_data
);

   logic load_accept;
   assign load_accept = req_valid && req_ready && req_data.mode;

   // A stalled bit holds.
   `SSSU_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // A word never breaks off before its last bit.
   `SSSU_ASSERT_NEXT(a_word_whole, clock, reset, rsp_valid && rsp_ready && !rsp_data.last, rsp_valid)

   // The digit conversion after a load blocks the input.
   `SSSU_ASSERT_NEXT(a_load_busy, clock, reset, load_accept, !req_ready)

   // The input stays blocked while the conversion is still running after the load.
   `SSSU_ASSERT_NOW(a_load_busy2, clock, reset, $past(load_accept, 2) && !$past(reset), !req_ready)

endmodule

bind seven_segment_scan_serializer_unit sssu_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);
